FILE: src/conversion_vertex_z_estimator_top_defines.svh
// Assertion macros for the conversion vertex z estimator.
// Included by the top level; needs no other file.
`ifndef CONVERSION_VERTEX_Z_ESTIMATOR_TOP_DEFINES_SVH
`define CONVERSION_VERTEX_Z_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CVZ_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("conversion vertex z estimator: check failed");

// Next-cycle implication, checked outside reset.
`define CVZ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("conversion vertex z estimator: check failed");

`endif

FILE: src/cvz_pkg.sv
// Shared codes and types of the conversion vertex z estimator.
// No dependencies; used by every module of the block.
package cvz_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BEAM_X       = 3'd0,
    REG_BEAM_Y       = 3'd1,
    REG_BEAM_Z       = 3'd2,
    REG_BARREL_LIMIT = 3'd3,
    REG_ENDCAP_LIMIT = 3'd4
  } reg_index_t;

  // Register reset values: 15 cm and 100 cm in 1/1024 cm.
  localparam int BARREL_LIMIT_RST = 15360;
  localparam int ENDCAP_LIMIT_RST = 102400;

  // Detector region codes that allow the projection method.
  localparam logic [1:0] DET_BARREL = 2'd1;
  localparam logic [1:0] DET_ENDCAP = 2'd2;

  typedef enum logic {
    METHOD_PROJ = 1'b0,
    METHOD_CALO = 1'b1
  } method_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: src/cvz_front.sv
// Front end: configuration registers, request intake and method selection.
// Depends on cvz_pkg.
module cvz_front
  import cvz_pkg::*;
#(
  parameter int COORD_BITS = 20,
  parameter int MOM_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  detector,
  input  logic signed [COORD_BITS-1:0] conv_x,
  input  logic signed [COORD_BITS-1:0] conv_y,
  input  logic signed [COORD_BITS-1:0] conv_z,
  input  logic signed [MOM_BITS-1:0]  mom_x,
  input  logic signed [MOM_BITS-1:0]  mom_y,
  input  logic signed [MOM_BITS-1:0]  mom_z,
  input  logic signed [COORD_BITS-1:0] calo_x,
  input  logic signed [COORD_BITS-1:0] calo_y,
  input  logic signed [COORD_BITS-1:0] calo_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        item_method,
  output logic                        item_zden,
  output logic signed [COORD_BITS-1:0] item_cz,
  output logic signed [MOM_BITS-1:0]  item_px,
  output logic signed [MOM_BITS-1:0]  item_py,
  output logic signed [MOM_BITS-1:0]  item_pz,
  output logic signed [COORD_BITS:0]  item_dx,
  output logic signed [COORD_BITS:0]  item_dy,
  output logic signed [COORD_BITS:0]  item_ex,
  output logic signed [COORD_BITS:0]  item_ey,
  output logic signed [COORD_BITS:0]  item_ez
);

  localparam int C = COORD_BITS;
  localparam int M = MOM_BITS;

  // Configuration registers.
  logic signed [C-1:0] beam_x;
  logic signed [C-1:0] beam_y;
  logic [C-2:0]        barrel_limit;
  logic [C-2:0]        endcap_limit;

  // Beam z does not enter either estimate, so its write is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_x       <= '0;
      beam_y       <= '0;
      barrel_limit <= (C-1)'(BARREL_LIMIT_RST);
      endcap_limit <= (C-1)'(ENDCAP_LIMIT_RST);
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_BEAM_X:       beam_x <= signed'(cfg_data);
        REG_BEAM_Y:       beam_y <= signed'(cfg_data);
        REG_BEAM_Z:       ;
        REG_BARREL_LIMIT: barrel_limit <= cfg_data[C-2:0];
        REG_ENDCAP_LIMIT: endcap_limit <= cfg_data[C-2:0];
        default:          ;
      endcase
    end
  end

  // Two-stage intake: capture, then squares and differences.
  logic                en;
  logic                f1_valid;
  logic [1:0]          f1_det;
  logic signed [C-1:0] f1_cx, f1_cy, f1_cz, f1_kx, f1_ky, f1_kz;
  logic signed [M-1:0] f1_px, f1_py, f1_pz;

  logic                f2_valid;
  logic signed [C-1:0] f2_cz;
  logic signed [M-1:0] f2_px, f2_py, f2_pz;
  logic signed [C:0]   f2_dx, f2_dy, f2_ex, f2_ey, f2_ez;
  logic [2*C-1:0]      f2_rsq;
  logic [2*C-3:0]      f2_lim2;
  logic                f2_barrel;
  logic                f2_endcap_ok;
  logic                f2_pzero;
  logic                f2_kzero;

  logic [C-1:0]        acx, acy, acz;
  logic signed [C:0]   dx, dy, ex, ey, ez;
  logic                proj;

  assign en       = !f2_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  // Magnitudes and offsets from the captured request.
  always_comb begin
    acx = f1_cx[C-1] ? C'(-f1_cx) : C'(f1_cx);
    acy = f1_cy[C-1] ? C'(-f1_cy) : C'(f1_cy);
    acz = f1_cz[C-1] ? C'(-f1_cz) : C'(f1_cz);
    dx  = (C+1)'(f1_cx) - (C+1)'(beam_x);
    dy  = (C+1)'(f1_cy) - (C+1)'(beam_y);
    ex  = (C+1)'(f1_kx) - (C+1)'(f1_cx);
    ey  = (C+1)'(f1_ky) - (C+1)'(f1_cy);
    ez  = (C+1)'(f1_kz) - (C+1)'(f1_cz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_det       <= detector;
      f1_cx        <= conv_x;
      f1_cy        <= conv_y;
      f1_cz        <= conv_z;
      f1_px        <= mom_x;
      f1_py        <= mom_y;
      f1_pz        <= mom_z;
      f1_kx        <= calo_x;
      f1_ky        <= calo_y;
      f1_kz        <= calo_z;
      f2_cz        <= f1_cz;
      f2_px        <= f1_px;
      f2_py        <= f1_py;
      f2_pz        <= f1_pz;
      f2_dx        <= dx;
      f2_dy        <= dy;
      f2_ex        <= ex;
      f2_ey        <= ey;
      f2_ez        <= ez;
      f2_rsq       <= (2*C)'(acx) * (2*C)'(acx) + (2*C)'(acy) * (2*C)'(acy);
      f2_lim2      <= (2*C-2)'(barrel_limit) * (2*C-2)'(barrel_limit);
      f2_barrel    <= (f1_det == DET_BARREL);
      f2_endcap_ok <= (f1_det == DET_ENDCAP) && (acz <= C'(endcap_limit));
      f2_pzero     <= (f1_px == '0) && (f1_py == '0);
      f2_kzero     <= (ex == '0) && (ey == '0);
    end
  end

  // Method choice and zero-denominator flag for the chosen method.
  assign proj        = (f2_barrel && (f2_rsq <= (2*C)'(f2_lim2))) || f2_endcap_ok;
  assign out_valid   = f2_valid;
  assign item_method = proj ? METHOD_PROJ : METHOD_CALO;
  assign item_zden   = proj ? f2_pzero : f2_kzero;
  assign item_cz     = f2_cz;
  assign item_px     = f2_px;
  assign item_py     = f2_py;
  assign item_pz     = f2_pz;
  assign item_dx     = f2_dx;
  assign item_dy     = f2_dy;
  assign item_ex     = f2_ex;
  assign item_ey     = f2_ey;
  assign item_ez     = f2_ez;

endmodule

FILE: src/cvz_queue.sv
// Short request queue between the front end and the arithmetic back end.
// Depends on cvz_pkg for the status struct.
module cvz_queue
  import cvz_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fifo_status_t     stat
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  assign rdata      = mem[rp];
  assign stat.full  = (count == (AW+1)'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

FILE: src/cvz_back.sv
// Back end: products, square roots, rounded division and saturation.
// Depends on cvz_pkg.
module cvz_back
  import cvz_pkg::*;
#(
  parameter int COORD_BITS = 20,
  parameter int MOM_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        item_method,
  input  logic                        item_zden,
  input  logic signed [COORD_BITS-1:0] item_cz,
  input  logic signed [MOM_BITS-1:0]  item_px,
  input  logic signed [MOM_BITS-1:0]  item_py,
  input  logic signed [MOM_BITS-1:0]  item_pz,
  input  logic signed [COORD_BITS:0]  item_dx,
  input  logic signed [COORD_BITS:0]  item_dy,
  input  logic signed [COORD_BITS:0]  item_ex,
  input  logic signed [COORD_BITS:0]  item_ey,
  input  logic signed [COORD_BITS:0]  item_ez,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS-1:0] vertex_z,
  output logic                        method,
  output logic [1:0]                  status
);

  localparam int C    = COORD_BITS;
  localparam int M    = MOM_BITS;
  localparam int PW   = C + M + 1;          // signed dx*px
  localparam int SW   = PW + 1;             // signed dot product
  localparam int SA   = PW;                 // its magnitude
  localparam int LO   = SA / 2;
  localparam int HI   = SA - LO;
  localparam int PT   = 2 * M;              // px^2 + py^2
  localparam int RB   = C + 1;              // root bits
  localparam int RS   = 2 * RB;             // squared length bits
  localparam int PNW  = SA + M;
  localparam int KNW  = RB + C + 1;
  localparam int NUMW = (PNW > KNW) ? PNW : KNW;
  localparam int NW   = NUMW + 1;
  localparam int DW   = (PT > RB) ? PT : RB;
  localparam int QB   = C + 1;
  localparam int RW   = (NW > DW + QB) ? NW : DW + QB;
  localparam int TW   = C + 3;

  localparam logic signed [TW-1:0] ZMAX = {{4{1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [TW-1:0] ZMIN = {{4{1'b1}}, {(C-1){1'b0}}};

  typedef struct packed {
    logic                method;
    logic                zden;
    logic                neg;
    logic signed [C-1:0] cz;
  } ctl_t;

  typedef struct packed {
    ctl_t          ctl;
    logic [SA-1:0] sabs;
    logic [M-1:0]  apz;
    logic [C:0]    aez;
    logic [PT-1:0] pt2;
    logic [RS-1:0] rem1;
    logic [RS-1:0] rem2;
    logic [RB-1:0] res1;
    logic [RB-1:0] res2;
  } sq_t;

  typedef struct packed {
    ctl_t          ctl;
    logic          over;
    logic [DW-1:0] d;
    logic [RW-1:0] r;
    logic [QB-1:0] q;
  } dv_t;

  // Whole back end advances together unless the result is held.
  logic ben;
  assign ben      = !out_valid || out_ready;
  assign in_ready = ben;

  // Stage 1: magnitudes and all first-level products.
  logic [C:0]   adx, ady, aex, aey, aez;
  logic [M-1:0] apx, apy, apz;

  always_comb begin
    adx = item_dx[C] ? (C+1)'(-item_dx) : (C+1)'(item_dx);
    ady = item_dy[C] ? (C+1)'(-item_dy) : (C+1)'(item_dy);
    aex = item_ex[C] ? (C+1)'(-item_ex) : (C+1)'(item_ex);
    aey = item_ey[C] ? (C+1)'(-item_ey) : (C+1)'(item_ey);
    aez = item_ez[C] ? (C+1)'(-item_ez) : (C+1)'(item_ez);
    apx = item_px[M-1] ? M'(-item_px) : M'(item_px);
    apy = item_py[M-1] ? M'(-item_py) : M'(item_py);
    apz = item_pz[M-1] ? M'(-item_pz) : M'(item_pz);
  end

  logic                 b1_v;
  ctl_t                 b1_ctl;
  logic                 b1_pzneg;
  logic [M-1:0]         b1_apz;
  logic [C:0]           b1_aez;
  logic signed [PW-1:0] b1_pdx, b1_pdy;
  logic [PT-1:0]        b1_px2, b1_py2;
  logic [RS-1:0]        b1_ex2, b1_ey2, b1_dx2, b1_dy2;

  always_ff @(posedge clk) begin
    if (ben) begin
      b1_ctl.method <= item_method;
      b1_ctl.zden   <= item_zden;
      b1_ctl.neg    <= item_ez[C];
      b1_ctl.cz     <= item_cz;
      b1_pzneg      <= item_pz[M-1];
      b1_apz        <= apz;
      b1_aez        <= aez;
      b1_pdx        <= PW'(item_dx) * PW'(item_px);
      b1_pdy        <= PW'(item_dy) * PW'(item_py);
      b1_px2        <= PT'(apx) * PT'(apx);
      b1_py2        <= PT'(apy) * PT'(apy);
      b1_ex2        <= RS'(aex) * RS'(aex);
      b1_ey2        <= RS'(aey) * RS'(aey);
      b1_dx2        <= RS'(adx) * RS'(adx);
      b1_dy2        <= RS'(ady) * RS'(ady);
    end
  end

  // Stage 2: sums.
  logic                 b2_v;
  ctl_t                 b2_ctl;
  logic                 b2_pzneg;
  logic [M-1:0]         b2_apz;
  logic [C:0]           b2_aez;
  logic signed [SW-1:0] b2_s;
  logic [PT-1:0]        b2_pt2;
  logic [RS-1:0]        b2_r1sq, b2_r2sq;

  always_ff @(posedge clk) begin
    if (ben) begin
      b2_ctl   <= b1_ctl;
      b2_pzneg <= b1_pzneg;
      b2_apz   <= b1_apz;
      b2_aez   <= b1_aez;
      b2_s     <= SW'(b1_pdx) + SW'(b1_pdy);
      b2_pt2   <= b1_px2 + b1_py2;
      b2_r1sq  <= b1_ex2 + b1_ey2;
      b2_r2sq  <= b1_dx2 + b1_dy2;
    end
  end

  // Stage 3 loads the square-root chain; the dot product sign is settled here.
  sq_t  sq   [RB+1];
  logic sq_v [RB+1];

  always_ff @(posedge clk) begin
    if (ben) begin
      sq[0].ctl.method <= b2_ctl.method;
      sq[0].ctl.zden   <= b2_ctl.zden;
      sq[0].ctl.cz     <= b2_ctl.cz;
      sq[0].ctl.neg    <= (b2_ctl.method == METHOD_PROJ) ? (b2_s[SW-1] ^ b2_pzneg)
                                                          : b2_ctl.neg;
      sq[0].sabs       <= b2_s[SW-1] ? SA'(-b2_s) : SA'(b2_s);
      sq[0].apz        <= b2_apz;
      sq[0].aez        <= b2_aez;
      sq[0].pt2        <= b2_pt2;
      sq[0].rem1       <= b2_r1sq;
      sq[0].rem2       <= b2_r2sq;
      sq[0].res1       <= '0;
      sq[0].res2       <= '0;
    end
  end

  // Digit-by-digit square roots of both squared lengths, one root bit a stage.
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int J = RB - 1 - k;
    sq_t           nx;
    logic [RS-1:0] t1, t2;

    always_comb begin
      nx = sq[k];
      t1 = (RS'(sq[k].res1) << (J + 1)) | (RS'(1) << (2 * J));
      t2 = (RS'(sq[k].res2) << (J + 1)) | (RS'(1) << (2 * J));
      if (sq[k].rem1 >= t1) begin
        nx.rem1 = sq[k].rem1 - t1;
        nx.res1 = sq[k].res1 | (RB'(1) << J);
      end
      if (sq[k].rem2 >= t2) begin
        nx.rem2 = sq[k].rem2 - t2;
        nx.res2 = sq[k].res2 | (RB'(1) << J);
      end
    end

    always_ff @(posedge clk) begin
      if (ben) sq[k+1] <= nx;
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (ben) sq_v[k+1] <= sq_v[k];
    end
  end

  // Numerator partial products and divisor choice.
  logic               m1_v;
  ctl_t               m1_ctl;
  logic [LO+M-1:0]    m1_plo;
  logic [HI+M-1:0]    m1_phi;
  logic [KNW-1:0]     m1_pnum;
  logic [DW-1:0]      m1_d;

  always_ff @(posedge clk) begin
    if (ben) begin
      m1_ctl  <= sq[RB].ctl;
      m1_plo  <= (LO+M)'(sq[RB].sabs[LO-1:0]) * (LO+M)'(sq[RB].apz);
      m1_phi  <= (HI+M)'(sq[RB].sabs[SA-1:LO]) * (HI+M)'(sq[RB].apz);
      m1_pnum <= KNW'(sq[RB].res2) * KNW'(sq[RB].aez);
      m1_d    <= (sq[RB].ctl.method == METHOD_PROJ) ? DW'(sq[RB].pt2) : DW'(sq[RB].res1);
    end
  end

  // Full numerator.
  logic            m2_v;
  ctl_t            m2_ctl;
  logic [NUMW-1:0] m2_num;
  logic [DW-1:0]   m2_d;

  always_ff @(posedge clk) begin
    if (ben) begin
      m2_ctl <= m1_ctl;
      m2_d   <= m1_d;
      m2_num <= (m1_ctl.method == METHOD_PROJ) ? (NUMW'(m1_phi) << LO) + NUMW'(m1_plo)
                                               : NUMW'(m1_pnum);
    end
  end

  // Rounding offset: half the divisor, so the floor rounds to nearest.
  dv_t  dv   [QB+1];
  logic dv_v [QB+1];

  always_ff @(posedge clk) begin
    if (ben) begin
      dv[0].ctl  <= m2_ctl;
      dv[0].over <= 1'b0;
      dv[0].d    <= m2_d;
      dv[0].r    <= RW'(m2_num) + RW'(m2_d >> 1);
      dv[0].q    <= '0;
    end
  end

  // Restoring division, one quotient bit a stage; the first stage also
  // flags a quotient too large for any in-range result.
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int I = QB - 1 - k;
    dv_t           nx;
    logic [RW-1:0] dsh;

    always_comb begin
      nx  = dv[k];
      dsh = RW'(dv[k].d) << I;
      if (k == 0) nx.over = (dv[k].r >= (RW'(dv[k].d) << QB));
      if (dv[k].r >= dsh) begin
        nx.r = dv[k].r - dsh;
        nx.q = dv[k].q | (QB'(1) << I);
      end
    end

    always_ff @(posedge clk) begin
      if (ben) dv[k+1] <= nx;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (ben) dv_v[k+1] <= dv_v[k];
    end
  end

  // Control pipeline valid flags of the fixed stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      sq_v[0]   <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      dv_v[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else if (ben) begin
      b1_v      <= in_valid;
      b2_v      <= b1_v;
      sq_v[0]   <= b2_v;
      m1_v      <= sq_v[RB];
      m2_v      <= m1_v;
      dv_v[0]   <= m2_v;
      out_valid <= dv_v[QB];
    end
  end

  // Final subtraction from conversion z and clamping.
  dv_t                  fin;
  logic signed [TW-1:0] t;
  logic signed [C-1:0]  z_next;
  logic [1:0]           st_next;

  always_comb begin
    fin = dv[QB];
    t   = fin.ctl.neg ? TW'(fin.ctl.cz) + $signed(TW'(fin.q))
                      : TW'(fin.ctl.cz) - $signed(TW'(fin.q));
    if (fin.ctl.zden) begin
      z_next  = '0;
      st_next = ST_ZERO_DEN;
    end else if (fin.over) begin
      z_next  = fin.ctl.neg ? C'(ZMAX) : C'(ZMIN);
      st_next = ST_SAT;
    end else if (t > ZMAX) begin
      z_next  = C'(ZMAX);
      st_next = ST_SAT;
    end else if (t < ZMIN) begin
      z_next  = C'(ZMIN);
      st_next = ST_SAT;
    end else begin
      z_next  = t[C-1:0];
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      vertex_z <= z_next;
      method   <= fin.ctl.method;
      status   <= st_next;
    end
  end

endmodule

FILE: src/conversion_vertex_z_estimator_top.sv
// Top level of the conversion vertex z estimator: front end, queue, back end.
// Depends on cvz_pkg, cvz_front, cvz_queue, cvz_back and the assertion header.
//
// Channel | Dir | Carries
// s_axis  | in  | one photon candidate per request
// m_axis  | out | one vertex z estimate per request
// cfg     | in  | register write, taken in the cycle of cfg_wen
//
// One request is accepted per cycle and one result leaves per cycle while
// m_axis is not held. Most of the pipeline stages lie in the square-root chain
// and the divider chain, each resolving one bit a stage.
// Reset is synchronous; it empties the pipeline and queue and loads the
// register defaults. A held m_axis freezes the back end; the four-entry
// queue then fills before s_axis_tready drops.
`include "conversion_vertex_z_estimator_top_defines.svh"

module conversion_vertex_z_estimator_top
  import cvz_pkg::*;
#(
  parameter int COORD_BITS = 20,
  parameter int MOM_BITS   = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // conv_x, conv_y, conv_z, mom_x, mom_y, mom_z, calo_x, calo_y, calo_z
  input  logic [((6*COORD_BITS+3*MOM_BITS+7)/8)*8-1:0] s_axis_tdata,
  // detector
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // vertex_z
  output logic [((COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // method, status
  output logic [2:0]                m_axis_tuser
);

  localparam int C  = COORD_BITS;
  localparam int M  = MOM_BITS;
  localparam int OW = ((C + 7) / 8) * 8;
  localparam int QW = 2 + C + 3 * M + 5 * (C + 1);

  // Input field slices.
  logic signed [C-1:0] conv_x, conv_y, conv_z, calo_x, calo_y, calo_z;
  logic signed [M-1:0] mom_x, mom_y, mom_z;

  assign conv_x = s_axis_tdata[C-1:0];
  assign conv_y = s_axis_tdata[2*C-1:C];
  assign conv_z = s_axis_tdata[3*C-1:2*C];
  assign mom_x  = s_axis_tdata[3*C+M-1:3*C];
  assign mom_y  = s_axis_tdata[3*C+2*M-1:3*C+M];
  assign mom_z  = s_axis_tdata[3*C+3*M-1:3*C+2*M];
  assign calo_x = s_axis_tdata[4*C+3*M-1:3*C+3*M];
  assign calo_y = s_axis_tdata[5*C+3*M-1:4*C+3*M];
  assign calo_z = s_axis_tdata[6*C+3*M-1:5*C+3*M];

  // Front end.
  logic                f_valid;
  logic                f_method, f_zden;
  logic signed [C-1:0] f_cz;
  logic signed [M-1:0] f_px, f_py, f_pz;
  logic signed [C:0]   f_dx, f_dy, f_ex, f_ey, f_ez;
  fifo_status_t        q_stat;
  logic                q_push, q_pop;
  logic [QW-1:0]       q_wdata, q_rdata;

  cvz_front #(.COORD_BITS(C), .MOM_BITS(M)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .detector    (s_axis_tuser),
    .conv_x      (conv_x),
    .conv_y      (conv_y),
    .conv_z      (conv_z),
    .mom_x       (mom_x),
    .mom_y       (mom_y),
    .mom_z       (mom_z),
    .calo_x      (calo_x),
    .calo_y      (calo_y),
    .calo_z      (calo_z),
    .out_valid   (f_valid),
    .out_ready   (!q_stat.full),
    .item_method (f_method),
    .item_zden   (f_zden),
    .item_cz     (f_cz),
    .item_px     (f_px),
    .item_py     (f_py),
    .item_pz     (f_pz),
    .item_dx     (f_dx),
    .item_dy     (f_dy),
    .item_ex     (f_ex),
    .item_ey     (f_ey),
    .item_ez     (f_ez)
  );

  // Classified requests wait here for the back end.
  assign q_push  = f_valid && !q_stat.full;
  assign q_wdata = {f_method, f_zden, f_cz, f_px, f_py, f_pz, f_dx, f_dy, f_ex, f_ey, f_ez};

  cvz_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end.
  logic                b_ready;
  logic                b_method, b_zden;
  logic signed [C-1:0] b_cz;
  logic signed [M-1:0] b_px, b_py, b_pz;
  logic signed [C:0]   b_dx, b_dy, b_ex, b_ey, b_ez;
  logic signed [C-1:0] vertex_z;
  logic                method;
  logic [1:0]          status;

  assign {b_method, b_zden, b_cz, b_px, b_py, b_pz, b_dx, b_dy, b_ex, b_ey, b_ez} = q_rdata;
  assign q_pop = b_ready && !q_stat.empty;

  cvz_back #(.COORD_BITS(C), .MOM_BITS(M)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!q_stat.empty),
    .in_ready    (b_ready),
    .item_method (b_method),
    .item_zden   (b_zden),
    .item_cz     (b_cz),
    .item_px     (b_px),
    .item_py     (b_py),
    .item_pz     (b_pz),
    .item_dx     (b_dx),
    .item_dy     (b_dy),
    .item_ex     (b_ex),
    .item_ey     (b_ey),
    .item_ez     (b_ez),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .vertex_z    (vertex_z),
    .method      (method),
    .status      (status)
  );

  assign m_axis_tdata = OW'(unsigned'(vertex_z));
  assign m_axis_tuser = {status, method};

  // A zero denominator always yields z of zero.
  `CVZ_ASSERT_NOW(a_zero_den_z, clk, rst, m_axis_tvalid && (status == ST_ZERO_DEN), vertex_z == '0)
  // A saturated result sits at one end of the range.
  `CVZ_ASSERT_NOW(a_sat_at_end, clk, rst, m_axis_tvalid && (status == ST_SAT), (vertex_z == {1'b0, {(C-1){1'b1}}}) || (vertex_z == {1'b1, {(C-1){1'b0}}}))
  // A held result must stop the back end from draining the queue.
  `CVZ_ASSERT_NOW(a_hold_no_pop, clk, rst, m_axis_tvalid && !m_axis_tready, !q_pop)
  // A written entry leaves the queue non-empty.
  `CVZ_ASSERT_NEXT(a_push_fills, clk, rst, q_push, !q_stat.empty)

endmodule
